// File: hw/rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection package
// Shared widths, transaction types and miss codes.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned PROD_BITS  = 2 * WORD_BITS;
  localparam int unsigned QUO_BITS   = WORD_BITS + 1;
  localparam int unsigned REM_BITS   = 3 * WORD_BITS + 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS  = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MISS_NONE     = 2'd0,
    MISS_PARALLEL = 2'd1,
    MISS_OUTSIDE  = 2'd2
  } miss_e;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] plane_px;
    logic signed [WORD_BITS-1:0] plane_py;
    logic signed [WORD_BITS-1:0] plane_pz;
    logic signed [WORD_BITS-1:0] normal_x;
    logic signed [WORD_BITS-1:0] normal_y;
    logic signed [WORD_BITS-1:0] normal_z;
    logic signed [WORD_BITS-1:0] start_x;
    logic signed [WORD_BITS-1:0] start_y;
    logic signed [WORD_BITS-1:0] start_z;
    logic signed [WORD_BITS-1:0] dir_x;
    logic signed [WORD_BITS-1:0] dir_y;
    logic signed [WORD_BITS-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic                        hit;
    logic [1:0]                  miss_code;
    logic signed [WORD_BITS-1:0] hit_x;
    logic signed [WORD_BITS-1:0] hit_y;
    logic signed [WORD_BITS-1:0] hit_z;
  } out_t;

  typedef struct packed {
    logic [2:0][WORD_BITS-1:0] start;
    logic [2:0][WORD_BITS-1:0] dir;
  } geom_t;

  typedef struct packed {
    miss_e                 code;
    logic [PROD_BITS-1:0]  num;
    logic [PROD_BITS-1:0]  den;
    geom_t                 geom;
  } job_t;

  typedef struct packed {
    miss_e                     code;
    logic [PROD_BITS-1:0]      den;
    logic [2:0]                neg;
    logic [2:0][WORD_BITS-1:0] start;
  } bk_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/spi_front.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection front end
// Forms both dot products, normalizes the sign and classifies the transaction.
// ----------------------------------------------------------------------------
module spi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  spi_pkg::in_t    in_i,
  output logic            push_o,
  output spi_pkg::job_t   job_o,
  input  spi_pkg::q_stat_t q_stat_i
);

  localparam int unsigned W = spi_pkg::WORD_BITS;
  localparam int unsigned P = spi_pkg::PROD_BITS;

  logic [4:0] vld_q;
  logic       en;

  spi_pkg::geom_t geom_q [5];

  logic signed [W-1:0]   n_q  [3];
  logic signed [W-1:0]   d_q  [3];
  logic signed [W:0]     df_q [3];
  logic signed [P-1:0]   dp_q [3];
  logic signed [P:0]     np_q [3];
  logic signed [P:0]     den_q;
  logic signed [P+1:0]   num_q;
  logic [P-1:0]          den_n_q;
  logic signed [P+2:0]   num_n_q;
  logic                  zero_q;
  spi_pkg::miss_e        code_q;
  logic [P-1:0]          num_o_q;
  logic [P-1:0]          den_o_q;

  logic signed [W-1:0] pv [3];
  logic signed [W-1:0] nv [3];
  logic signed [W-1:0] sv [3];
  logic signed [W-1:0] dv [3];
  logic signed [P+2:0] num_ext;
  logic signed [P:0]   den_abs;
  spi_pkg::geom_t      geom_in;

  assign en         = !(vld_q[4] && q_stat_i.full);
  assign in_stall_o = !en;
  assign push_o     = vld_q[4] && en;

  always_comb begin
    pv[0] = in_i.plane_px;  pv[1] = in_i.plane_py;  pv[2] = in_i.plane_pz;
    nv[0] = in_i.normal_x;  nv[1] = in_i.normal_y;  nv[2] = in_i.normal_z;
    sv[0] = in_i.start_x;   sv[1] = in_i.start_y;   sv[2] = in_i.start_z;
    dv[0] = in_i.dir_x;     dv[1] = in_i.dir_y;     dv[2] = in_i.dir_z;
    for (int c = 0; c < 3; c++) begin
      geom_in.start[c] = sv[c];
      geom_in.dir[c]   = dv[c];
    end
    num_ext = (P+3)'(num_q);
    den_abs = den_q[P] ? -den_q : den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geom_q[0] <= geom_in;
      for (int s = 1; s < 5; s++) geom_q[s] <= geom_q[s-1];
      for (int c = 0; c < 3; c++) begin
        n_q[c]  <= nv[c];
        d_q[c]  <= dv[c];
        df_q[c] <= (W+1)'(pv[c]) - (W+1)'(sv[c]);
        dp_q[c] <= P'(n_q[c]) * P'(d_q[c]);
        np_q[c] <= (P+1)'(n_q[c]) * (P+1)'(df_q[c]);
      end
      den_q   <= (P+1)'(dp_q[0]) + (P+1)'(dp_q[1]) + (P+1)'(dp_q[2]);
      num_q   <= (P+2)'(np_q[0]) + (P+2)'(np_q[1]) + (P+2)'(np_q[2]);
      zero_q  <= (den_q == '0);
      den_n_q <= den_abs[P-1:0];
      num_n_q <= den_q[P] ? -num_ext : num_ext;
      num_o_q <= num_n_q[P-1:0];
      den_o_q <= den_n_q;
      priority if (zero_q) begin
        code_q <= spi_pkg::MISS_PARALLEL;
      end else if (num_n_q[P+2] || ($unsigned(num_n_q) > {3'b000, den_n_q})) begin
        code_q <= spi_pkg::MISS_OUTSIDE;
      end else begin
        code_q <= spi_pkg::MISS_NONE;
      end
    end
  end

  always_comb begin
    job_o.code = code_q;
    job_o.num  = num_o_q;
    job_o.den  = den_o_q;
    job_o.geom = geom_q[4];
  end

endmodule

// File: hw/rtl/spi_queue.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection job queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module spi_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  spi_pkg::job_t    job_i,
  input  logic             pop_i,
  output spi_pkg::job_t    job_o,
  output spi_pkg::q_stat_t stat_o
);

  localparam int unsigned D  = spi_pkg::QUEUE_DEPTH;
  localparam int unsigned PB = spi_pkg::QPTR_BITS;

  spi_pkg::job_t mem_q [D];
  logic [PB-1:0] wr_q, rd_q;
  logic [PB:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (PB+1)'(D));
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PB+1)'(push_i) - (PB+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// File: hw/rtl/spi_back.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection back end
// Scales each direction by t through a pipelined divider, rounds and saturates.
// ----------------------------------------------------------------------------
module spi_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spi_pkg::job_t    job_i,
  input  spi_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output spi_pkg::out_t    out_o
);

  localparam int unsigned W   = spi_pkg::WORD_BITS;
  localparam int unsigned P   = spi_pkg::PROD_BITS;
  localparam int unsigned QW  = spi_pkg::QUO_BITS;
  localparam int unsigned RW  = spi_pkg::REM_BITS;
  localparam int unsigned NST = 3 + QW;

  logic en;
  logic [NST-1:0] vld_q;
  logic           vo_q;
  spi_pkg::bk_ctl_t ctl_q [NST];
  spi_pkg::out_t    out_q;

  logic [2*W-1:0] pplo_q [3];
  logic [2*W-1:0] pphi_q [3];
  logic [3*W-1:0] pr_q   [3];
  logic [RW-1:0]  rem_q  [QW+1][3];
  logic [QW-1:0]  quo_q  [QW+1][3];

  logic [W-1:0]        absd [3];
  spi_pkg::bk_ctl_t    ctl_in;
  spi_pkg::out_t       out_d;
  logic signed [QW:0]  off  [3];
  logic signed [W+1:0] res  [3];
  logic signed [W-1:0] sat  [3];

  localparam logic signed [W+1:0] MaxVal = (W+2)'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [W+1:0] MinVal = -MaxVal - 1;

  assign en          = !(vo_q && out_stall_i);
  assign pop_o       = en && !q_stat_i.empty;
  assign out_valid_o = vo_q;
  assign out_o       = out_q;

  always_comb begin
    ctl_in.code = job_i.code;
    ctl_in.den  = job_i.den;
    for (int c = 0; c < 3; c++) begin
      ctl_in.neg[c]   = job_i.geom.dir[c][W-1];
      ctl_in.start[c] = job_i.geom.start[c];
      absd[c] = job_i.geom.dir[c][W-1] ? -job_i.geom.dir[c] : job_i.geom.dir[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vo_q  <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], pop_o};
      vo_q  <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= ctl_in;
      for (int s = 1; s < NST; s++) ctl_q[s] <= ctl_q[s-1];
      for (int c = 0; c < 3; c++) begin
        pplo_q[c]   <= (2*W)'(job_i.num[W-1:0]) * (2*W)'(absd[c]);
        pphi_q[c]   <= (2*W)'(job_i.num[P-1:W]) * (2*W)'(absd[c]);
        pr_q[c]     <= (3*W)'(pplo_q[c]) + {pphi_q[c][W-1:0], {W{1'b0}}}
                       + {pphi_q[c][2*W-1:W], {(2*W){1'b0}}};
        rem_q[0][c] <= {pr_q[c], 1'b0} + RW'(ctl_q[1].den);
        quo_q[0][c] <= '0;
      end
      out_q <= out_d;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned K = QW - 1 - j;
    logic [RW-1:0] dsh [3];
    logic          ge  [3];
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        dsh[c] = RW'({ctl_q[2+j].den, 1'b0}) << K;
        ge[c]  = (rem_q[j][c] >= dsh[c]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          rem_q[j+1][c] <= ge[c] ? rem_q[j][c] - dsh[c] : rem_q[j][c];
          quo_q[j+1][c] <= quo_q[j][c] | (QW'(ge[c]) << K);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      off[c] = ctl_q[NST-1].neg[c] ? -$signed({1'b0, quo_q[QW][c]})
                                   :  $signed({1'b0, quo_q[QW][c]});
      res[c] = (W+2)'($signed(ctl_q[NST-1].start[c])) + (W+2)'(off[c]);
      priority if (res[c] > MaxVal) begin
        sat[c] = MaxVal[W-1:0];
      end else if (res[c] < MinVal) begin
        sat[c] = MinVal[W-1:0];
      end else begin
        sat[c] = res[c][W-1:0];
      end
    end
    out_d.miss_code = ctl_q[NST-1].code;
    out_d.hit       = (ctl_q[NST-1].code == spi_pkg::MISS_NONE);
    out_d.hit_x     = out_d.hit ? sat[0] : '0;
    out_d.hit_y     = out_d.hit ? sat[1] : '0;
    out_d.hit_z     = out_d.hit ? sat[2] : '0;
  end

endmodule

// File: hw/rtl/segment_plane_intersect_unit.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection unit
// Exact fixed-point segment/plane intersection, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless stalled and returns one result per
// transaction, in order. Five front-end stages form and classify the dot
// products, a four-entry queue follows, then the back end scales the
// direction and feeds a restoring divider that retires one quotient bit per
// stage for all three axes, followed by the output register. Either side may
// stall without losing throughput.
module segment_plane_intersect_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spi_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spi_pkg::out_t out_o
);

  logic             push, pop;
  spi_pkg::job_t    job_wr, job_rd;
  spi_pkg::q_stat_t q_stat;

  spi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .push_o(push), .job_o(job_wr), .q_stat_i(q_stat)
  );

  spi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_wr),
    .pop_i(pop), .job_o(job_rd), .stat_o(q_stat)
  );

  spi_back u_back (
    .clk_i, .rst_ni, .job_i(job_rd), .q_stat_i(q_stat), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_o
  );

endmodule

// File: hw/rtl/spi_checker.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection port checker
// Watches the top-level ports for result consistency.
// ----------------------------------------------------------------------------
module spi_port_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input spi_pkg::out_t out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.miss_code == spi_pkg::MISS_NONE ||
                     out_o.miss_code == spi_pkg::MISS_PARALLEL ||
                     out_o.miss_code == spi_pkg::MISS_OUTSIDE))
    else $error("bad miss code");

  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.hit == (out_o.miss_code == spi_pkg::MISS_NONE)))
    else $error("hit flag disagrees with miss code");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.hit |->
      (out_o.hit_x == '0 && out_o.hit_y == '0 && out_o.hit_z == '0))
    else $error("miss carries a nonzero point");

endmodule

bind segment_plane_intersect_unit spi_port_checker u_spi_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_o
);

// File: sim/spi_checker.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection checker
// Watches both channels, predicts each result exactly and compares in order.
// ----------------------------------------------------------------------------
module spi_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  spi_pkg::in_t  in_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  spi_pkg::out_t out_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            hit_count_o,
  output int            parallel_count_o,
  output int            outside_count_o
);

  spi_pkg::out_t expected_q[$];

  function automatic logic signed [31:0] round_coord(logic signed [31:0] s,
                                                     logic signed [31:0] d,
                                                     logic signed [127:0] num,
                                                     logic signed [127:0] den);
    logic signed [127:0] prod;
    logic signed [127:0] mag;
    logic signed [127:0] off;
    logic signed [127:0] res;
    begin
      prod = num * d;
      mag  = (prod < 0) ? -prod : prod;
      off  = (2 * mag + den) / (2 * den);
      if (prod < 0) off = -off;
      res = s + off;
      if (res > 128'sd2147483647) res = 128'sd2147483647;
      if (res < -128'sd2147483648) res = -128'sd2147483648;
      round_coord = res[31:0];
    end
  endfunction

  function automatic spi_pkg::out_t predict_intersection(spi_pkg::in_t t);
    logic signed [127:0] num;
    logic signed [127:0] den;
    spi_pkg::out_t r;
    begin
      num = 0;
      den = 0;
      r   = '0;
      den = 128'(t.normal_x) * 128'(t.dir_x) + 128'(t.normal_y) * 128'(t.dir_y)
          + 128'(t.normal_z) * 128'(t.dir_z);
      num = 128'(t.normal_x) * (128'(t.plane_px) - 128'(t.start_x))
          + 128'(t.normal_y) * (128'(t.plane_py) - 128'(t.start_y))
          + 128'(t.normal_z) * (128'(t.plane_pz) - 128'(t.start_z));
      if (den == 0) begin
        r.miss_code = spi_pkg::MISS_PARALLEL;
      end else begin
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        if (num < 0 || num > den) begin
          r.miss_code = spi_pkg::MISS_OUTSIDE;
        end else begin
          r.hit       = 1'b1;
          r.miss_code = spi_pkg::MISS_NONE;
          r.hit_x     = round_coord(t.start_x, t.dir_x, num, den);
          r.hit_y     = round_coord(t.start_y, t.dir_y, num, den);
          r.hit_z     = round_coord(t.start_z, t.dir_z, num, den);
        end
      end
      predict_intersection = r;
    end
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    hit_count_o = 0;
    parallel_count_o = 0;
    outside_count_o = 0;
  end

  always @(posedge clk_i) begin
    spi_pkg::out_t e;
    int errs;
    errs = 0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        e = predict_intersection(in_i);
        expected_q.push_back(e);
        if (e.hit) hit_count_o <= hit_count_o + 1;
        else if (e.miss_code == spi_pkg::MISS_PARALLEL)
          parallel_count_o <= parallel_count_o + 1;
        else outside_count_o <= outside_count_o + 1;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_i.hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, out_i.hit);
            errs++;
          end
          if (out_i.miss_code !== e.miss_code) begin
            $error("miss_code: expected %0d actual %0d", e.miss_code, out_i.miss_code);
            errs++;
          end
          if (out_i.hit_x !== e.hit_x) begin
            $error("hit_x: expected %h actual %h", e.hit_x, out_i.hit_x);
            errs++;
          end
          if (out_i.hit_y !== e.hit_y) begin
            $error("hit_y: expected %h actual %h", e.hit_y, out_i.hit_y);
            errs++;
          end
          if (out_i.hit_z !== e.hit_z) begin
            $error("hit_z: expected %h actual %h", e.hit_z, out_i.hit_z);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
    pending_o <= expected_q.size();
  end
endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Segment/plane intersection testbench
// Drives directed and random geometry with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_RANDOM = 1950;
  localparam int QUIET_FROM = 1700;
  localparam int CYCLE_LIMIT = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  spi_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  spi_pkg::out_t out_data;
  int    fail_count;
  int    pending;
  int    hit_count;
  int    parallel_count;
  int    outside_count;
  int    cycle_count = 0;
  int    sent = 0;
  bit    quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  segment_plane_intersect_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  spi_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_i            (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_i           (out_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .hit_count_o     (hit_count),
    .parallel_count_o(parallel_count),
    .outside_count_o (outside_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
    end
  end

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: rand_word = $urandom;
      1: rand_word = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      2: rand_word = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: rand_word = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endcase
  endfunction

  function automatic spi_pkg::in_t random_item();
    spi_pkg::in_t t;
    int  mode;
    logic signed [31:0] lam;
    begin
      mode = $urandom_range(0, 9);
      t.plane_px = rand_word(mode > 2 ? 1 : mode % 3);
      t.plane_py = rand_word(mode > 2 ? 1 : mode % 3);
      t.plane_pz = rand_word(mode > 2 ? 1 : mode % 3);
      t.normal_x = rand_word(mode > 2 ? 3 : mode % 3);
      t.normal_y = rand_word(mode > 2 ? 3 : mode % 3);
      t.normal_z = rand_word(mode > 2 ? 3 : mode % 3);
      t.start_x  = rand_word(mode > 2 ? 1 : mode % 3);
      t.start_y  = rand_word(mode > 2 ? 1 : mode % 3);
      t.start_z  = rand_word(mode > 2 ? 1 : mode % 3);
      t.dir_x    = rand_word(mode > 2 ? 3 : mode % 3);
      t.dir_y    = rand_word(mode > 2 ? 3 : mode % 3);
      t.dir_z    = rand_word(mode > 2 ? 3 : mode % 3);
      if (mode >= 4 && mode <= 7) begin
        lam = $signed($urandom_range(0, 32'h0001_0000));
        t.plane_px = t.start_x + 32'((64'(t.dir_x) * 64'(lam)) >>> 16);
        t.plane_py = t.start_y + 32'((64'(t.dir_y) * 64'(lam)) >>> 16);
        t.plane_pz = t.start_z + 32'((64'(t.dir_z) * 64'(lam)) >>> 16);
      end else if (mode == 8) begin
        t.dir_z = '0;
        t.normal_x = '0;
        t.normal_y = '0;
      end
      random_item = t;
    end
  endfunction

  task automatic send_item(spi_pkg::in_t t);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    spi_pkg::in_t t;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hit at t = 1/2 along z
    t = '0;
    t.normal_z = 32'h0001_0000;
    t.plane_pz = 32'h0000_8000;
    t.dir_z    = 32'h0001_0000;
    send_item(t);
    // endpoint t = 0
    t.plane_pz = 32'h0;
    send_item(t);
    // endpoint t = 1
    t.plane_pz = 32'h0001_0000;
    send_item(t);
    // outside beyond the end and before the start
    t.plane_pz = 32'h0002_0000;
    send_item(t);
    t.plane_pz = 32'hffff_0000;
    send_item(t);
    // negative denominator
    t.dir_z    = 32'hffff_0000;
    t.plane_pz = 32'hffff_8000;
    send_item(t);
    // parallel, segment in plane, and zero normal
    t.dir_z = '0;
    t.dir_x = 32'h0001_0000;
    send_item(t);
    t.plane_pz = '0;
    send_item(t);
    t = '0;
    t.dir_x = 32'h7fff_ffff;
    send_item(t);
    // extremes: all max, all min, mixed
    t = {12{32'h7fff_ffff}};
    send_item(t);
    t = {12{32'h8000_0000}};
    send_item(t);
    t = '0;
    t.normal_x = 32'h8000_0000;
    t.start_x  = 32'h7fff_ffff;
    t.dir_x    = 32'h8000_0000;
    t.plane_px = 32'h8000_0000;
    send_item(t);
    t.start_x  = 32'h8000_0000;
    t.dir_x    = 32'h7fff_ffff;
    t.plane_px = 32'h7fff_ffff;
    send_item(t);
    t = '1;
    send_item(t);
    // rounding tie: t = 1/2 on an odd direction
    t = '0;
    t.normal_x = 32'h2;
    t.plane_px = 32'h1;
    t.dir_x    = 32'h2;
    t.dir_y    = 32'h1;
    t.dir_z    = 32'hffff_ffff;
    send_item(t);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      send_item(random_item());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d transactions: %0d hits, %0d parallel, %0d outside",
             sent, hit_count, parallel_count, outside_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: segment_plane_intersect_unit.f
hw/rtl/spi_pkg.sv
hw/rtl/spi_front.sv
hw/rtl/spi_queue.sv
hw/rtl/spi_back.sv
hw/rtl/segment_plane_intersect_unit.sv
hw/rtl/spi_checker.sv
sim/spi_checker.sv
sim/tb_top.sv
